### rtl/lfmcg_pkg.sv
// Package for the LFM chirp generator: register indexes, sample widths and
// the quarter-wave sine function used to build the constant table.
// No dependencies.
`default_nettype none

package lfmcg_pkg;

  localparam int unsigned AMP_W    = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned REG_W    = 32;
  localparam int unsigned LEN_W    = 24;

  typedef enum logic [1:0] {
    CFG_START_STEP     = 2'd0,
    CFG_STEP_INCREMENT = 2'd1,
    CFG_AMPLITUDE      = 2'd2,
    CFG_CHIRP_LENGTH   = 2'd3
  } cfg_idx_e;

  // Q30 coefficients of sin(pi/2 * x), x in [0,1]
  localparam logic [63:0] K1 = 64'd1686629713;
  localparam logic [63:0] K3 = 64'd693598669;
  localparam logic [63:0] K5 = 64'd85569306;
  localparam logic [63:0] K7 = 64'd5026995;
  localparam logic [63:0] K9 = 64'd172272;

  // Q15 magnitude of sin(pi/2 * r / 2^(addr_bits-2)); elaboration use only
  function automatic logic [AMP_W-1:0] quarter_sine(input int unsigned r,
                                                    input int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] x3;
    logic [63:0] x5;
    logic [63:0] x7;
    logic [63:0] x9;
    logic [63:0] s;
    x  = 64'(r) << (30 - (addr_bits - 2));
    x2 = (x * x) >> 30;
    x3 = (x2 * x) >> 30;
    x5 = (x3 * x2) >> 30;
    x7 = (x5 * x2) >> 30;
    x9 = (x7 * x2) >> 30;
    s  = (K1 * x) >> 30;
    s  = s - ((K3 * x3) >> 30);
    s  = s + ((K5 * x5) >> 30);
    s  = s - ((K7 * x7) >> 30);
    s  = s + ((K9 * x9) >> 30);
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[AMP_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/lfmcg_phase.sv
// Phase stage: phase and step accumulators, sample counter and last flag.
// Registers the table address of each accepted item. Uses lfmcg_pkg.
`default_nettype none

module lfmcg_phase #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned COUNT_BITS      = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_restart_i,
  output logic                                   in_ready_o,
  input  wire logic [lfmcg_pkg::REG_W-1:0]        start_step_i,
  input  wire logic signed [lfmcg_pkg::REG_W-1:0] step_increment_i,
  input  wire logic [lfmcg_pkg::LEN_W-1:0]        chirp_length_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [TABLE_ADDR_BITS-1:0]             out_addr_o,
  output logic                                   out_last_o
);

  localparam int unsigned CMP_W =
    ((COUNT_BITS > lfmcg_pkg::LEN_W) ? COUNT_BITS : lfmcg_pkg::LEN_W) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [PHASE_BITS-1:0]      phase_q, phase_d;
  logic [PHASE_BITS-1:0]      step_q, step_d;
  logic [COUNT_BITS-1:0]      index_q, index_d;
  logic                       valid_q;
  logic [TABLE_ADDR_BITS-1:0] addr_q;
  logic                       last_q;

  logic                       accept;
  logic [COUNT_BITS-1:0]      index_cur;
  logic                       first;
  logic [PHASE_BITS-1:0]      phase_cur;
  logic [PHASE_BITS-1:0]      step_cur;
  logic                       last_d;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    index_cur = in_restart_i ? '0 : index_q;
    first     = (index_cur == '0);
    phase_cur = first ? '0 : phase_q;
    step_cur  = first ? PHASE_BITS'(start_step_i) : step_q;
    last_d    = ((CMP_W'(index_cur) + CMP_W'(1)) >= CMP_W'(chirp_length_i))
                || (index_cur == CNT_MAX);
    phase_d   = phase_cur + step_cur;
    step_d    = step_cur + PHASE_BITS'(step_increment_i);
    index_d   = last_d ? '0 : index_cur + COUNT_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
      index_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        step_q  <= step_d;
        index_q <= index_d;
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= phase_cur[PHASE_BITS-1 -: TABLE_ADDR_BITS];
      last_q <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_addr_o  = addr_q;
  assign out_last_o  = last_q;

`ifndef ASSERT_OFF
  a_restart_phase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_restart_i |=> addr_q == '0)
    else $error("restart item did not start at phase zero");

  a_last_clears_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_d |=> index_q == '0 && last_q)
    else $error("sample counter not cleared after last item");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !last_d |=> index_q == $past(index_cur) + COUNT_BITS'(1))
    else $error("sample counter did not advance by one");
`endif

endmodule

`default_nettype wire

### rtl/lfmcg_sincos.sv
// Table stage: quarter-wave sine table and quadrant folding for the
// cosine and sine of the registered address. Uses lfmcg_pkg.
`default_nettype none

module lfmcg_sincos #(
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [TABLE_ADDR_BITS-1:0]   in_addr_i,
  input  wire logic                         in_last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              out_cos_neg_o,
  output logic [lfmcg_pkg::AMP_W-1:0]       out_cos_mag_o,
  output logic                              out_sin_neg_o,
  output logic [lfmcg_pkg::AMP_W-1:0]       out_sin_mag_o,
  output logic                              out_last_o
);

  localparam int unsigned QUARTER = 1 << (TABLE_ADDR_BITS - 2);
  localparam logic [TABLE_ADDR_BITS-1:0] QUARTER_ADDR = TABLE_ADDR_BITS'(QUARTER);
  localparam logic [TABLE_ADDR_BITS-2:0] QUARTER_IDX  = (TABLE_ADDR_BITS-1)'(QUARTER);

  logic [lfmcg_pkg::AMP_W-1:0] rom [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    assign rom[k] = lfmcg_pkg::quarter_sine(k, TABLE_ADDR_BITS);
  end

  logic                         valid_q;
  logic                         cos_neg_q, sin_neg_q, last_q;
  logic [lfmcg_pkg::AMP_W-1:0]  cos_mag_q, sin_mag_q;

  logic [TABLE_ADDR_BITS-1:0]   cos_addr;
  logic [TABLE_ADDR_BITS-2:0]   cos_idx, sin_idx;
  logic                         accept;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cos_addr   = in_addr_i + QUARTER_ADDR;

  always_comb begin
    sin_idx = {1'b0, in_addr_i[TABLE_ADDR_BITS-3:0]};
    if (in_addr_i[TABLE_ADDR_BITS-2]) begin
      sin_idx = QUARTER_IDX - sin_idx;
    end
    cos_idx = {1'b0, cos_addr[TABLE_ADDR_BITS-3:0]};
    if (cos_addr[TABLE_ADDR_BITS-2]) begin
      cos_idx = QUARTER_IDX - cos_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sin_neg_q <= in_addr_i[TABLE_ADDR_BITS-1];
      sin_mag_q <= rom[sin_idx];
      cos_neg_q <= cos_addr[TABLE_ADDR_BITS-1];
      cos_mag_q <= rom[cos_idx];
      last_q    <= in_last_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_cos_neg_o = cos_neg_q;
  assign out_cos_mag_o = cos_mag_q;
  assign out_sin_neg_o = sin_neg_q;
  assign out_sin_mag_o = sin_mag_q;
  assign out_last_o    = last_q;

endmodule

`default_nettype wire

### rtl/lfmcg_scale.sv
// Output stage: amplitude scaling with truncation toward zero and the
// result register. Uses lfmcg_pkg.
`default_nettype none

module lfmcg_scale (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [lfmcg_pkg::AMP_W-1:0]        amplitude_i,
  input  wire logic                               in_cos_neg_i,
  input  wire logic [lfmcg_pkg::AMP_W-1:0]        in_cos_mag_i,
  input  wire logic                               in_sin_neg_i,
  input  wire logic [lfmcg_pkg::AMP_W-1:0]        in_sin_mag_i,
  input  wire logic                               in_last_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [lfmcg_pkg::SAMPLE_W-1:0]   out_i_sample_o,
  output logic signed [lfmcg_pkg::SAMPLE_W-1:0]   out_q_sample_o,
  output logic                                    out_last_o
);

  localparam int unsigned PROD_W = 2 * lfmcg_pkg::AMP_W;

  logic                                  valid_q;
  logic signed [lfmcg_pkg::SAMPLE_W-1:0] i_q, q_q;
  logic                                  last_q;

  logic [PROD_W-1:0]                     cos_prod, sin_prod;
  logic [lfmcg_pkg::SAMPLE_W-1:0]        cos_p, sin_p;
  logic                                  accept;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cos_prod = PROD_W'(amplitude_i) * PROD_W'(in_cos_mag_i);
    sin_prod = PROD_W'(amplitude_i) * PROD_W'(in_sin_mag_i);
    cos_p    = {1'b0, cos_prod[PROD_W-1 -: lfmcg_pkg::AMP_W]};
    sin_p    = {1'b0, sin_prod[PROD_W-1 -: lfmcg_pkg::AMP_W]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      i_q    <= in_cos_neg_i ? -cos_p : cos_p;
      q_q    <= in_sin_neg_i ? -sin_p : sin_p;
      last_q <= in_last_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_i_sample_o = i_q;
  assign out_q_sample_o = q_q;
  assign out_last_o     = last_q;

`ifndef ASSERT_OFF
  a_i_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (i_q[lfmcg_pkg::SAMPLE_W-1] ? -i_q : i_q) <= $past({1'b0, amplitude_i}))
    else $error("in-phase sample exceeds amplitude");

  a_q_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (q_q[lfmcg_pkg::SAMPLE_W-1] ? -q_q : q_q) <= $past({1'b0, amplitude_i}))
    else $error("quadrature sample exceeds amplitude");
`endif

endmodule

`default_nettype wire

### rtl/lfm_chirp_generator_top.sv
// LFM chirp generator (DDS style) top level: configuration registers and
// the three pipeline stages. Uses lfmcg_pkg, lfmcg_phase, lfmcg_sincos, lfmcg_scale.
//
// One complex sample per input item, one item per clock cycle sustained while
// the output is not stalled. Each item passes three registered stages (accumulators,
// quarter-wave table, amplitude multiply) before its sample reaches the output;
// the phase and step accumulators update in the cycle an item is accepted, which
// sets the one-item-per-cycle figure. s_axis_tready drops only when all three
// stages hold samples and the output is stalled. The sine table is a constant
// of 2^(TABLE_ADDR_BITS-2)+1 quarter-wave entries. The user must write registers
// only while no item is in flight; the block itself does not enforce this.
`default_nettype none

module lfm_chirp_generator_top #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned COUNT_BITS      = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] i_sample, [31:16] q_sample
  output logic             m_axis_tlast
);

  logic [lfmcg_pkg::REG_W-1:0]        start_step_q;
  logic signed [lfmcg_pkg::REG_W-1:0] step_increment_q;
  logic [lfmcg_pkg::AMP_W-1:0]        amplitude_q;
  logic [lfmcg_pkg::LEN_W-1:0]        chirp_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_step_q     <= '0;
      step_increment_q <= '0;
      amplitude_q      <= lfmcg_pkg::AMP_W'(1800);
      chirp_length_q   <= lfmcg_pkg::LEN_W'(5000);
    end else if (cfg_we_i) begin
      unique case (lfmcg_pkg::cfg_idx_e'(cfg_addr_i))
        lfmcg_pkg::CFG_START_STEP:     start_step_q     <= cfg_data_i;
        lfmcg_pkg::CFG_STEP_INCREMENT: step_increment_q <= cfg_data_i;
        lfmcg_pkg::CFG_AMPLITUDE:      amplitude_q      <= cfg_data_i[lfmcg_pkg::AMP_W-1:0];
        lfmcg_pkg::CFG_CHIRP_LENGTH:   chirp_length_q   <= cfg_data_i[lfmcg_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic                        ph_valid, ph_ready, ph_last;
  logic [TABLE_ADDR_BITS-1:0]  ph_addr;
  logic                        sc_valid, sc_ready, sc_last;
  logic                        sc_cos_neg, sc_sin_neg;
  logic [lfmcg_pkg::AMP_W-1:0] sc_cos_mag, sc_sin_mag;
  logic signed [lfmcg_pkg::SAMPLE_W-1:0] i_sample, q_sample;

  lfmcg_phase #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_phase (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_restart_i     (s_axis_tdata[0]),
    .in_ready_o       (s_axis_tready),
    .start_step_i     (start_step_q),
    .step_increment_i (step_increment_q),
    .chirp_length_i   (chirp_length_q),
    .out_valid_o      (ph_valid),
    .out_ready_i      (ph_ready),
    .out_addr_o       (ph_addr),
    .out_last_o       (ph_last)
  );

  lfmcg_sincos #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_sincos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (ph_valid),
    .in_ready_o    (ph_ready),
    .in_addr_i     (ph_addr),
    .in_last_i     (ph_last),
    .out_valid_o   (sc_valid),
    .out_ready_i   (sc_ready),
    .out_cos_neg_o (sc_cos_neg),
    .out_cos_mag_o (sc_cos_mag),
    .out_sin_neg_o (sc_sin_neg),
    .out_sin_mag_o (sc_sin_mag),
    .out_last_o    (sc_last)
  );

  lfmcg_scale u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (sc_valid),
    .in_ready_o     (sc_ready),
    .amplitude_i    (amplitude_q),
    .in_cos_neg_i   (sc_cos_neg),
    .in_cos_mag_i   (sc_cos_mag),
    .in_sin_neg_i   (sc_sin_neg),
    .in_sin_mag_i   (sc_sin_mag),
    .in_last_i      (sc_last),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_i_sample_o (i_sample),
    .out_q_sample_o (q_sample),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {q_sample, i_sample};

endmodule

`default_nettype wire

### test/lfm_chirp_generator_top_test.sv
// Self-checking bench for lfm_chirp_generator_top: a directed table then random
// chirp settings, each output sample compared against the table's expected values or an in-bench DDS predictor.
// Depends on lfmcg_pkg and the RTL under rtl/.
`default_nettype none

module lfm_chirp_generator_top_test;

  localparam int unsigned CYCLE_LIMIT = 300000;

  // Q30 coefficients, odd powers of sin(pi/2 * x)
  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598669;
  localparam logic [63:0] SIN_C5 = 64'd85569306;
  localparam logic [63:0] SIN_C7 = 64'd5026995;
  localparam logic [63:0] SIN_C9 = 64'd172272;

  typedef struct packed {
    logic [15:0] i_val;
    logic [15:0] q_val;
    logic        last;
  } chirp_sample_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    lfmcg_pkg::cfg_idx_e reg_idx;
    logic [31:0]         value;
    bit                  restart;
    bit                  known;
    chirp_sample_t       want;
  } plan_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_addr_i    = 2'd0;
  logic [31:0] cfg_data_i    = 32'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  lfm_chirp_generator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [0] restart, [7:1] zero
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [15:0] i_sample, [31:16] q_sample
    .m_axis_tlast  (m_axis_tlast)
  );

  // register shadows and chirp state
  logic [31:0]        reg_start = 32'd0;
  logic signed [31:0] reg_rate  = 32'sd0;
  logic [14:0]        reg_amp   = 15'd1800;
  logic [23:0]        reg_len   = 24'd5000;
  logic [31:0]        chirp_phase = 32'd0;
  logic [31:0]        chirp_step  = 32'd0;
  logic [23:0]        chirp_pos   = 24'd0;

  int            sine_lut [1024];
  chirp_sample_t pending_samples [$];
  int unsigned   error_count = 0;
  bit            quiet = 1'b0;
  int unsigned   cycle_count = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int quarter_wave(int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] x3;
    logic [63:0] x5;
    logic [63:0] x7;
    logic [63:0] x9;
    logic [63:0] acc;
    x   = 64'(r) << 22;
    x2  = (x * x) >> 30;
    x3  = (x2 * x) >> 30;
    x5  = (x3 * x2) >> 30;
    x7  = (x5 * x2) >> 30;
    x9  = (x7 * x2) >> 30;
    acc = (SIN_C1 * x) >> 30;
    acc = acc - ((SIN_C3 * x3) >> 30);
    acc = acc + ((SIN_C5 * x5) >> 30);
    acc = acc - ((SIN_C7 * x7) >> 30);
    acc = acc + ((SIN_C9 * x9) >> 30);
    acc = (acc + 64'd16384) >> 15;
    if (acc > 64'd32767) begin
      acc = 64'd32767;
    end
    return int'(acc);
  endfunction

  function automatic logic [15:0] scale_by_amp(int v);
    logic [31:0] mag;
    logic [31:0] prod;
    mag  = (v < 0) ? 32'(-v) : 32'(v);
    prod = (32'(reg_amp) * mag) >> 15;
    return (v < 0) ? 16'(-prod) : prod[15:0];
  endfunction

  task automatic next_sample(input bit restart, output chirp_sample_t s);
    logic [9:0] addr;
    logic       last;
    if (restart) begin
      chirp_pos = '0;
    end
    if (chirp_pos == '0) begin
      chirp_phase = '0;
      chirp_step  = reg_start;
    end
    addr    = chirp_phase[31:22];
    s.i_val = scale_by_amp(sine_lut[10'(addr + 10'd256)]);
    s.q_val = scale_by_amp(sine_lut[addr]);
    last    = ({1'b0, chirp_pos} + 25'd1 >= {1'b0, reg_len}) || (chirp_pos == 24'hFFFFFF);
    s.last  = last;
    chirp_phase = chirp_phase + chirp_step;
    chirp_step  = chirp_step + reg_rate;
    chirp_pos   = last ? 24'd0 : chirp_pos + 24'd1;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    error_count++;
  endtask

  // waits until every expected sample has come out, plus pipeline slack
  task automatic drain_samples();
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(lfmcg_pkg::cfg_idx_e idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      lfmcg_pkg::CFG_START_STEP:     reg_start = data;
      lfmcg_pkg::CFG_STEP_INCREMENT: reg_rate  = data;
      lfmcg_pkg::CFG_AMPLITUDE:      reg_amp   = data[14:0];
      lfmcg_pkg::CFG_CHIRP_LENGTH:   reg_len   = data[23:0];
      default: ;
    endcase
  endtask

  task automatic send_tick(bit restart, bit known, chirp_sample_t want);
    chirp_sample_t s;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    next_sample(restart, s);
    pending_samples.push_back(known ? want : s);
    if (!quiet && $urandom_range(0, 99) < 5) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic pick_settings();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0:       v = 32'd0;
      1:       v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    write_reg(lfmcg_pkg::CFG_START_STEP, v);
    case ($urandom_range(0, 4))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = $urandom_range(0, 1) ? 32'($urandom_range(0, 65535))
                                        : -32'($urandom_range(0, 65535));
      default: v = $urandom;
    endcase
    write_reg(lfmcg_pkg::CFG_STEP_INCREMENT, v);
    case ($urandom_range(0, 3))
      0:       v = 32'd0;
      1:       v = 32'd32767;
      default: v = 32'($urandom_range(0, 32767));
    endcase
    v[31:15] = 17'($urandom);
    write_reg(lfmcg_pkg::CFG_AMPLITUDE, v);
    case ($urandom_range(0, 5))
      0:       v = 32'd1;
      1:       v = 32'd0;
      2:       v = 32'hFF_FFFF;
      default: v = 32'($urandom_range(2, 400));
    endcase
    v[31:24] = 8'($urandom);
    write_reg(lfmcg_pkg::CFG_CHIRP_LENGTH, v);
  endtask

  // output side: check accepted samples, stall at random
  initial begin
    chirp_sample_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pending_samples.size() == 0) begin
          report_mismatch("unexpected sample i", $signed(m_axis_tdata[15:0]), 0);
        end else begin
          want = pending_samples.pop_front();
          if (m_axis_tdata[15:0] !== want.i_val)
            report_mismatch("i_sample", $signed(m_axis_tdata[15:0]), $signed(want.i_val));
          if (m_axis_tdata[31:16] !== want.q_val)
            report_mismatch("q_sample", $signed(m_axis_tdata[31:16]), $signed(want.q_val));
          if (m_axis_tlast !== want.last)
            report_mismatch("last", m_axis_tlast, want.last);
        end
      end
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 10);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    plan_row_t plan [$];
    int        quad;
    int        r;
    int        m;
    plan = '{
      // after reset: phase 0, amplitude 1800
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b1, '{16'd1799, 16'd0, 1'b0}},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b1, 1'b1, '{16'd1799, 16'd0, 1'b0}},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b1, '{16'd1799, 16'd0, 1'b0}},
      // full amplitude, upper write bits ignored
      '{ROW_WRITE, lfmcg_pkg::CFG_AMPLITUDE, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b1, '{16'd32766, 16'd0, 1'b0}},
      // quarter-turn step walks the four axes
      '{ROW_WRITE, lfmcg_pkg::CFG_START_STEP, 32'h4000_0000, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b1, 1'b1, '{16'd32766, 16'd0, 1'b0}},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b1, '{16'd0, 16'd32766, 1'b0}},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b1, '{-16'sd32766, 16'd0, 1'b0}},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b1, '{16'd0, -16'sd32766, 1'b0}},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b1, '{16'd32766, 16'd0, 1'b0}},
      '{ROW_WRITE, lfmcg_pkg::CFG_AMPLITUDE, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b1, '{16'd0, 16'd0, 1'b0}},
      // one-sample chirps, then length zero acting as one
      '{ROW_WRITE, lfmcg_pkg::CFG_AMPLITUDE, 32'h0000_7FFF, 1'b0, 1'b0, '0},
      '{ROW_WRITE, lfmcg_pkg::CFG_CHIRP_LENGTH, 32'd1, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b1, 1'b1, '{16'd32766, 16'd0, 1'b1}},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b1, '{16'd32766, 16'd0, 1'b1}},
      '{ROW_WRITE, lfmcg_pkg::CFG_CHIRP_LENGTH, 32'hFF00_0000, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b1, '{16'd32766, 16'd0, 1'b1}},
      // short chirp, most negative rate
      '{ROW_WRITE, lfmcg_pkg::CFG_CHIRP_LENGTH, 32'd3, 1'b0, 1'b0, '0},
      '{ROW_WRITE, lfmcg_pkg::CFG_START_STEP, 32'h8000_0000, 1'b0, 1'b0, '0},
      '{ROW_WRITE, lfmcg_pkg::CFG_STEP_INCREMENT, 32'h8000_0000, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b1, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b0, '0},
      // top step, most positive rate, longest chirp
      '{ROW_WRITE, lfmcg_pkg::CFG_START_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{ROW_WRITE, lfmcg_pkg::CFG_STEP_INCREMENT, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
      '{ROW_WRITE, lfmcg_pkg::CFG_CHIRP_LENGTH, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b1, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b0, '0},
      // start step changed mid-chirp: holds until restart
      '{ROW_WRITE, lfmcg_pkg::CFG_STEP_INCREMENT, 32'h0000_1000, 1'b0, 1'b0, '0},
      '{ROW_WRITE, lfmcg_pkg::CFG_START_STEP, 32'h0123_4567, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b1, 1'b0, '0},
      '{ROW_ITEM,  lfmcg_pkg::CFG_START_STEP, 32'd0, 1'b0, 1'b0, '0}
    };

    for (int a = 0; a < 1024; a++) begin
      quad = a >> 8;
      r    = a & 255;
      if (quad & 1) begin
        r = 256 - r;
      end
      m = quarter_wave(r);
      sine_lut[a] = (quad & 2) ? -m : m;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[n]) begin
      if (plan[n].kind == ROW_WRITE) begin
        s_axis_tvalid <= 1'b0;
        drain_samples();
        write_reg(plan[n].reg_idx, plan[n].value);
      end else begin
        send_tick(plan[n].restart, plan[n].known, plan[n].want);
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      s_axis_tvalid <= 1'b0;
      drain_samples();
      quiet = (phase == 3);
      pick_settings();
      for (int k = 0; k < 250; k++) begin
        send_tick($urandom_range(0, 99) < 3, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;
    drain_samples();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
